// ----- src/rtru_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtru_pkg
// Types and constants for the RV32 trap, privilege and reservation unit.
// ----------------------------------------------------------------------------
package rtru_pkg;

    // Request codes; the two unused codes fall to a default arm.
    typedef enum logic [2:0] {
        REQ_TRAP    = 3'd0,
        REQ_RETURN  = 3'd1,
        REQ_EXT_IRQ = 3'd2,
        REQ_LR      = 3'd3,
        REQ_SC      = 3'd4,
        REQ_STORE   = 3'd5
    } req_type_t;

    // Configuration register indexes (byte address / 4).
    typedef enum logic [2:0] {
        CFG_MTVEC    = 3'd0,
        CFG_STVEC    = 3'd1,
        CFG_MEDELEG  = 3'd2,
        CFG_MIDELEG  = 3'd3,
        CFG_SEIE     = 3'd4
    } cfg_index_t;

    localparam logic [1:0] PRIV_USER    = 2'd0;
    localparam logic [1:0] PRIV_SUPER   = 2'd1;
    localparam logic [1:0] PRIV_MACHINE = 2'd3;

    localparam logic [31:0] EXT_IRQ_CAUSE = 32'h8000_0009;
    localparam logic [31:0] SRET_CLEAR    = 32'h0000_0122;
    localparam logic [31:0] MRET_CLEAR    = 32'h0000_1888;
    localparam logic [32:0] RESERVE_BYTES = 33'd4;

    // mstatus bit positions
    localparam int SIE_POS  = 1;
    localparam int MIE_POS  = 3;
    localparam int SPIE_POS = 5;
    localparam int MPIE_POS = 7;
    localparam int SPP_POS  = 8;
    localparam int MPP_LSB  = 11;

    localparam int PADDR_W = 5;

endpackage

// ----- src/riscv_trap_and_reservation_unit_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riscv_trap_and_reservation_unit_top
// RV32 trap / privilege unit with an LR/SC reservation and an APB config port.
// ----------------------------------------------------------------------------
// Each request transfer (trap, SRET/MRET, external interrupt, load-reserve,
// store-conditional, plain store) produces exactly one result transfer. A
// request is captured in an input register, evaluated against the
// architectural state (mode, mstatus, epc/cause/tval pairs, reservation,
// pending bit) by one level of combinational logic, and the result plus the
// new state are written together on the same edge. Result valid is set
// when the input register moves into the result register, which rsp_stall
// can hold off; throughput is one request per cycle while rsp_stall is
// low. A request waits in the input register while the result register is
// held by rsp_stall, so req_stall follows rsp_stall only when both stages
// are full.
// The configuration registers (trap vectors, delegation masks, external
// interrupt enable) sit at byte addresses 0, 4, 8, 12 and 16 and are meant
// to be written only while no request is in flight. There is no memory and
// no clearing pass after reset.
// ----------------------------------------------------------------------------
module riscv_trap_and_reservation_unit_top
    import rtru_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // APB configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,

    // request channel
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [2:0]           req_type,
    input  logic [4:0]           cause_code,
    input  logic                 is_interrupt,
    input  logic [31:0]          trap_value,
    input  logic [31:0]          current_pc,
    input  logic                 return_to_machine,
    input  logic [31:0]          access_address,
    input  logic [3:0]           store_size,

    // result channel
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic                 redirect,
    output logic [31:0]          next_pc,
    output logic [1:0]           privilege,
    output logic                 sc_success,
    output logic                 trap_to_supervisor,
    output logic [31:0]          status_word,
    output logic                 ext_irq_pending
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] mtvec_reg;
    logic [31:0] stvec_reg;
    logic [31:0] medeleg_reg;
    logic [31:0] mideleg_reg;
    logic        seie_reg;
    logic        cfg_write;
    cfg_index_t  cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = cfg_index_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtvec_reg   <= '0;
            stvec_reg   <= '0;
            medeleg_reg <= '0;
            mideleg_reg <= '0;
            seie_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                CFG_MTVEC:   mtvec_reg   <= pwdata;
                CFG_STVEC:   stvec_reg   <= pwdata;
                CFG_MEDELEG: medeleg_reg <= pwdata;
                CFG_MIDELEG: mideleg_reg <= pwdata;
                CFG_SEIE:    seie_reg    <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            CFG_MTVEC:   prdata = mtvec_reg;
            CFG_STVEC:   prdata = stvec_reg;
            CFG_MEDELEG: prdata = medeleg_reg;
            CFG_MIDELEG: prdata = mideleg_reg;
            CFG_SEIE:    prdata = {31'd0, seie_reg};
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: input register -> result register
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic advance;      // input register moves into the result register
    logic req_take;     // request transfer this cycle

    assign advance   = s1_valid_reg && (!rsp_valid || !rsp_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    req_type_t   s1_req_reg;
    logic [4:0]  s1_cause_reg;
    logic        s1_intr_reg;
    logic [31:0] s1_tval_reg;
    logic [31:0] s1_pc_reg;
    logic        s1_ret_m_reg;
    logic [31:0] s1_addr_reg;
    logic [3:0]  s1_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req_take)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_req_reg   <= req_type_t'(req_type);
            s1_cause_reg <= cause_code;
            s1_intr_reg  <= is_interrupt;
            s1_tval_reg  <= trap_value;
            s1_pc_reg    <= current_pc;
            s1_ret_m_reg <= return_to_machine;
            s1_addr_reg  <= access_address;
            s1_size_reg  <= store_size;
        end
    end

    // ------------------------------------------------------------------
    // Architectural state
    // ------------------------------------------------------------------
    logic [1:0]  priv_reg,    priv_next;
    logic [31:0] mstatus_reg, mstatus_next;
    logic [31:0] sepc_reg,    sepc_next;
    logic [31:0] scause_reg,  scause_next;
    logic [31:0] stval_reg,   stval_next;
    logic [31:0] mepc_reg,    mepc_next;
    logic [31:0] mcause_reg,  mcause_next;
    logic [31:0] mtval_reg,   mtval_next;
    logic [31:0] resv_addr_reg, resv_addr_next;
    logic        resv_valid_reg, resv_valid_next;
    logic        pending_reg, pending_next;

    // per-request results
    logic        redirect_next;
    logic [31:0] next_pc_next;
    logic        sc_ok_next;
    logic        to_sup_next;

    // trap entry temporaries
    logic        take_trap;
    logic [31:0] trap_cause;
    logic [31:0] trap_tval;
    logic        deleg;
    logic        irq_enabled;
    logic [32:0] st_end;
    logic [32:0] resv_end;
    logic        overlap;

    assign irq_enabled = (priv_reg != PRIV_MACHINE) && seie_reg &&
                         ((priv_reg == PRIV_USER) ||
                          ((priv_reg == PRIV_SUPER) && mstatus_reg[SIE_POS]));

    // no wrap: both ends are 33 bits wide
    assign st_end   = {1'b0, s1_addr_reg} + {29'd0, s1_size_reg};
    assign resv_end = {1'b0, resv_addr_reg} + RESERVE_BYTES;
    assign overlap  = ({1'b0, s1_addr_reg} < resv_end) &&
                      (st_end > {1'b0, resv_addr_reg});

    always_comb
    begin
        priv_next       = priv_reg;
        mstatus_next    = mstatus_reg;
        sepc_next       = sepc_reg;
        scause_next     = scause_reg;
        stval_next      = stval_reg;
        mepc_next       = mepc_reg;
        mcause_next     = mcause_reg;
        mtval_next      = mtval_reg;
        resv_addr_next  = resv_addr_reg;
        resv_valid_next = resv_valid_reg;
        pending_next    = pending_reg;
        redirect_next   = 1'b0;
        next_pc_next    = '0;
        sc_ok_next      = 1'b0;
        to_sup_next     = 1'b0;
        take_trap       = 1'b0;
        trap_cause      = '0;
        trap_tval       = '0;
        deleg           = 1'b0;

        case (s1_req_reg)
            REQ_TRAP:
            begin
                take_trap  = 1'b1;
                trap_cause = {s1_intr_reg, 26'd0, s1_cause_reg};
                trap_tval  = s1_tval_reg;
            end
            REQ_RETURN:
            begin
                redirect_next = 1'b1;
                if (s1_ret_m_reg)
                begin
                    next_pc_next          = mepc_reg;
                    priv_next             = mstatus_reg[MPP_LSB +: 2];
                    mstatus_next          = mstatus_reg & ~MRET_CLEAR;
                    mstatus_next[MIE_POS] = mstatus_reg[MPIE_POS];
                    mstatus_next[MPIE_POS] = 1'b1;
                end
                else
                begin
                    next_pc_next           = sepc_reg;
                    priv_next              = {1'b0, mstatus_reg[SPP_POS]};
                    mstatus_next           = mstatus_reg & ~SRET_CLEAR;
                    mstatus_next[SIE_POS]  = mstatus_reg[SPIE_POS];
                    mstatus_next[SPIE_POS] = 1'b1;
                end
            end
            REQ_EXT_IRQ:
            begin
                if (irq_enabled)
                begin
                    pending_next = 1'b1;
                    take_trap    = 1'b1;
                    trap_cause   = EXT_IRQ_CAUSE;
                end
            end
            REQ_LR:
            begin
                resv_addr_next  = s1_addr_reg;
                resv_valid_next = 1'b1;
            end
            REQ_SC:
            begin
                sc_ok_next      = resv_valid_reg && (resv_addr_reg == s1_addr_reg);
                resv_valid_next = 1'b0;
            end
            REQ_STORE:
            begin
                if (resv_valid_reg && overlap)
                    resv_valid_next = 1'b0;
            end
            default: ;
        endcase

        // trap entry; the request cases above leave status untouched here
        if (take_trap)
        begin
            resv_valid_next = 1'b0;
            redirect_next   = 1'b1;
            if (priv_reg == PRIV_USER || priv_reg == PRIV_SUPER)
                deleg = trap_cause[31] ? mideleg_reg[trap_cause[4:0]]
                                       : medeleg_reg[trap_cause[4:0]];
            to_sup_next = deleg;
            if (deleg)
            begin
                sepc_next              = s1_pc_reg;
                scause_next            = trap_cause;
                stval_next             = trap_tval;
                mstatus_next[SIE_POS]  = 1'b0;
                mstatus_next[SPIE_POS] = mstatus_reg[SIE_POS];
                mstatus_next[SPP_POS]  = priv_reg[0];
                priv_next              = PRIV_SUPER;
                next_pc_next           = {stvec_reg[31:2], 2'b00};
            end
            else
            begin
                mepc_next                    = s1_pc_reg;
                mcause_next                  = trap_cause;
                mtval_next                   = trap_tval;
                mstatus_next[MIE_POS]        = 1'b0;
                mstatus_next[MPIE_POS]       = mstatus_reg[MIE_POS];
                mstatus_next[MPP_LSB +: 2]   = priv_reg;
                priv_next                    = PRIV_MACHINE;
                next_pc_next                 = {mtvec_reg[31:2], 2'b00};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            priv_reg       <= PRIV_MACHINE;
            mstatus_reg    <= '0;
            sepc_reg       <= '0;
            scause_reg     <= '0;
            stval_reg      <= '0;
            mepc_reg       <= '0;
            mcause_reg     <= '0;
            mtval_reg      <= '0;
            resv_addr_reg  <= '0;
            resv_valid_reg <= 1'b0;
            pending_reg    <= 1'b0;
        end
        else if (advance)
        begin
            priv_reg       <= priv_next;
            mstatus_reg    <= mstatus_next;
            sepc_reg       <= sepc_next;
            scause_reg     <= scause_next;
            stval_reg      <= stval_next;
            mepc_reg       <= mepc_next;
            mcause_reg     <= mcause_next;
            mtval_reg      <= mtval_next;
            resv_addr_reg  <= resv_addr_next;
            resv_valid_reg <= resv_valid_next;
            pending_reg    <= pending_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic        rsp_valid_reg;
    logic        redirect_reg;
    logic [31:0] next_pc_reg;
    logic [1:0]  privilege_reg;
    logic        sc_success_reg;
    logic        to_sup_reg;
    logic [31:0] status_reg;
    logic        irq_pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (advance)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            redirect_reg   <= redirect_next;
            next_pc_reg    <= next_pc_next;
            privilege_reg  <= priv_next;
            sc_success_reg <= sc_ok_next;
            to_sup_reg     <= to_sup_next;
            status_reg     <= mstatus_next;
            irq_pend_reg   <= pending_next;
        end
    end

    assign rsp_valid          = rsp_valid_reg;
    assign redirect           = redirect_reg;
    assign next_pc            = next_pc_reg;
    assign privilege          = privilege_reg;
    assign sc_success         = sc_success_reg;
    assign trap_to_supervisor = to_sup_reg;
    assign status_word        = status_reg;
    assign ext_irq_pending    = irq_pend_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // no target is shown without a redirect
    a_no_target: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !redirect |-> next_pc == '0)
        else $error("next_pc nonzero without redirect");

    // a delegated trap always lands in supervisor mode
    a_deleg_mode: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && trap_to_supervisor |-> privilege == PRIV_SUPER && redirect)
        else $error("delegated trap not in supervisor mode");

    // a successful store-conditional kills the reservation
    a_sc_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && sc_ok_next |=> !resv_valid_reg)
        else $error("reservation survived store-conditional");

    // the pending bit is sticky until reset
    a_pending_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |=> pending_reg)
        else $error("pending external interrupt bit cleared");

    // the mode register never holds the reserved encoding
    a_priv_legal: assert property (@(posedge clk) disable iff (!rst_n)
        priv_reg != 2'd2)
        else $error("illegal privilege mode");

endmodule
